@@ rtl/core/oaht_pkg.sv @@
package oaht_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int SLOT_W      = 4;
    localparam int STATUS_W    = 2;

    // Configuration registers
    localparam int TSIZE_W     = 5;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'b1;
    localparam logic [TSIZE_W-1:0]   TABLE_SIZE_RESET = 5'd11;

    // Key reduction: one digit of the key per cycle
    localparam int DIGIT_W    = 4;
    localparam int HASH_STEPS = KEY_W / DIGIT_W;
    localparam int HCNT_W     = $clog2(HASH_STEPS);

    // Request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Probe modes
    localparam logic MODE_LINEAR    = 1'b0;
    localparam logic MODE_QUADRATIC = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic hash_step;
        logic probe_start;
        logic probe_next;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic probe_end;
    } dp_stat_t;

endpackage

@@ rtl/core/oaht_ctrl.sv @@
module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_START,
        S_PROBE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [HCNT_W-1:0]   hcnt_reg;
    logic [HCNT_W-1:0]   hcnt_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                out_free;

    // The response register can take a new result when empty or being drained.
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Sequencing of one transaction: reduce the key, then probe slot by slot.
    always_comb
    begin
        state_next = state_reg;
        hcnt_next  = hcnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    hcnt_next  = '0;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                hcnt_next     = hcnt_reg + HCNT_W'(1);
                if (hcnt_reg == HCNT_W'(HASH_STEPS - 1))
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.probe_start = 1'b1;
                state_next      = S_PROBE;
            end
            S_PROBE:
            begin
                if (stat.probe_end)
                begin
                    if (out_free)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response valid flag follows the commit and the downstream handshake.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hcnt_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hcnt_reg      <= hcnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

@@ rtl/core/oaht_dp.sv @@
module oaht_dp
    import oaht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  req_t                 req,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output rsp_t                 rsp
);

    localparam int CMP_W = (TSIZE_W > SIZE_W) ? TSIZE_W : SIZE_W;

    logic [TSIZE_W-1:0]     table_size_reg;
    logic                   probe_mode_reg;
    logic                   lookup_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [KEY_W-1:0]       key_sh_reg;
    logic [SIZE_W-1:0]      rem_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [SIZE_W-1:0]      k_reg;
    rsp_t                   rsp_reg;
    logic [KEY_W-1:0]       keys_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [CMP_W-1:0]       ts_ext;
    logic [SIZE_W-1:0]      size;
    logic [SIZE_W:0]        size_ext;
    logic [SIZE_W:0]        rem_t;
    logic [SIZE_W-1:0]      rem_next;
    logic                   cur_valid;
    logic                   is_match;
    logic                   last_probe;
    logic [SIZE_W:0]        odd;
    logic [SIZE_W-1:0]      delta;
    logic [SIZE_W:0]        sum;
    logic [IDX_W-1:0]       idx_next;
    rsp_t                   rsp_next;
    logic                   store;

    // Effective table size: zero acts as one, anything above the depth is clipped.
    always_comb
    begin
        ts_ext = CMP_W'(table_size_reg);
        if (table_size_reg == '0)
        begin
            size = SIZE_W'(1);
        end
        else if (ts_ext > CMP_W'(TABLE_DEPTH))
        begin
            size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            size = SIZE_W'(ts_ext);
        end
    end

    assign size_ext = {1'b0, size};

    // Remainder of the key by the size, one digit per cycle, MSB first.
    always_comb
    begin
        rem_next = rem_reg;
        rem_t    = '0;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            rem_t = {rem_next, key_sh_reg[KEY_W-1-i]};
            if (rem_t >= size_ext)
            begin
                rem_t = rem_t - size_ext;
            end
            rem_next = rem_t[SIZE_W-1:0];
        end
    end

    // Current slot check
    assign cur_valid  = valid_reg[idx_reg];
    assign is_match   = lookup_reg && cur_valid && (keys_reg[idx_reg] == key_reg);
    assign last_probe = (k_reg == (size - SIZE_W'(1)));
    assign stat.probe_end = !cur_valid || is_match || last_probe;

    // Step to the next probe slot: linear adds one, quadratic adds 2k+1.
    always_comb
    begin
        odd = {k_reg, 1'b1};
        if (odd >= size_ext)
        begin
            odd = odd - size_ext;
        end
        if (probe_mode_reg == MODE_QUADRATIC)
        begin
            delta = odd[SIZE_W-1:0];
        end
        else
        begin
            delta = (size == SIZE_W'(1)) ? '0 : SIZE_W'(1);
        end
        sum = {1'b0, SIZE_W'(idx_reg)} + {1'b0, delta};
        if (sum >= size_ext)
        begin
            sum = sum - size_ext;
        end
        idx_next = IDX_W'(sum);
    end

    // Outcome of the transaction at the slot where probing ends.
    always_comb
    begin
        rsp_next.status = ST_NOT_FOUND;
        rsp_next.slot   = '0;
        if (!cur_valid)
        begin
            if (lookup_reg)
            begin
                rsp_next.status = ST_NOT_FOUND;
            end
            else
            begin
                rsp_next.status = ST_INSERTED;
                rsp_next.slot   = SLOT_W'(idx_reg);
            end
        end
        else if (is_match)
        begin
            rsp_next.status = ST_FOUND;
            rsp_next.slot   = SLOT_W'(idx_reg);
        end
        else
        begin
            rsp_next.status = lookup_reg ? ST_NOT_FOUND : ST_FULL;
        end
    end

    assign store = cmd.commit && !cur_valid && !lookup_reg;
    assign rsp   = rsp_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
            probe_mode_reg <= MODE_LINEAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE_SIZE: table_size_reg <= cfg_data[TSIZE_W-1:0];
                REG_PROBE_MODE: probe_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Slot valid bits; reset empties the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (store)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Working registers, key store and response payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lookup_reg <= (req.req_type == REQ_LOOKUP);
            key_reg    <= req.key;
            key_sh_reg <= req.key;
            rem_reg    <= '0;
        end
        if (cmd.hash_step)
        begin
            key_sh_reg <= key_sh_reg << DIGIT_W;
            rem_reg    <= rem_next;
        end
        if (cmd.probe_start)
        begin
            idx_reg <= IDX_W'(rem_reg);
            k_reg   <= '0;
        end
        if (cmd.probe_next)
        begin
            idx_reg <= idx_next;
            k_reg   <= k_reg + SIZE_W'(1);
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
        if (store)
        begin
            keys_reg[idx_reg] <= key_reg;
        end
    end

endmodule

@@ rtl/core/open_address_hash_table_unit.sv @@
// Open-addressing hash table with linear or quadratic probing.
// Request channel (req_valid/req_ready, req): a transaction carries an insert
// or lookup request and a 32-bit key. Response channel (rsp_valid/rsp_ready,
// rsp): one transaction per request with a status and a slot index.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 table size,
// 1 probe mode); write only while no request is in flight.
// Sequence: the key is reduced modulo the table size one 4-bit digit per cycle,
// then one slot is probed per cycle, with 1 up to the table size probes. The
// response is registered when probing ends, and the next request is taken
// once the controller is back in idle.
// One request is worked on at a time; a new request can be taken while the
// previous response still waits in the output register.
// When the receiver stalls, the response holds, and a finished probe waits
// in place until the output register frees.
// Reset empties the table, sets the size to 11 and selects linear probing.
module open_address_hash_table_unit
    import oaht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    oaht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, hash and probe datapath
    oaht_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule

@@ rtl/core/oaht_chk.sv @@
module oaht_chk
    import oaht_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input rsp_t                 rsp
);

    // A stalled response transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

    // Requests are worked on one at a time: ready drops after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

    // A failed request reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL)
        |-> rsp.slot == '0)
    else $error("failed request with nonzero slot");

    // No response appears in the cycle right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> !rsp_valid)
    else $error("response too early");

endmodule

bind open_address_hash_table_unit oaht_chk u_oaht_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

@@ bench/hash_table_checker.sv @@
module hash_table_checker
    import oaht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  req_t                 req,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rsp_t                 rsp,
    output int                   fail_count,
    output int                   pending
);

    // Shadow copy of the table contents and of the two registers.
    logic [KEY_W-1:0]   stored_key  [TABLE_DEPTH];
    logic               slot_filled [TABLE_DEPTH];
    logic [TSIZE_W-1:0] size_reg;
    logic               mode_reg;

    // Responses still owed by the block, oldest first.
    rsp_t awaited_rsp [$];
    rsp_t oldest;

    // Number of slots actually in use; zero acts as one, large sizes clamp to the depth.
    function automatic int unsigned active_slots();
        int unsigned n;
        n = size_reg;
        if (n == 0)
            n = 1;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        return n;
    endfunction

    // Walk the probe sequence for one request, update the shadow table and
    // return the response the block has to give.
    function automatic rsp_t serve_request(req_t r);
        int unsigned n;
        int unsigned home;
        int unsigned idx;
        rsp_t        res;
        n          = active_slots();
        home       = r.key % n;
        res.status = (r.req_type == REQ_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
        res.slot   = '0;
        for (int unsigned k = 0; k < n; k++)
        begin
            if (mode_reg == MODE_QUADRATIC)
                idx = (home + (k * k) % n) % n;
            else
                idx = (home + k) % n;
            // An empty slot ends both kinds of request; an insert claims it.
            if (!slot_filled[idx])
            begin
                if (r.req_type == REQ_INSERT)
                begin
                    stored_key[idx]  = r.key;
                    slot_filled[idx] = 1'b1;
                    res.status       = ST_INSERTED;
                    res.slot         = idx[SLOT_W-1:0];
                end
                break;
            end
            if (r.req_type == REQ_LOOKUP && stored_key[idx] == r.key)
            begin
                res.status = ST_FOUND;
                res.slot   = idx[SLOT_W-1:0];
                break;
            end
        end
        return res;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch: %s is %0d, predicted %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Compare completed responses, then predict newly accepted requests and
    // track register writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_filled[i] = 1'b0;
            size_reg = TABLE_SIZE_RESET;
            mode_reg = MODE_LINEAR;
            awaited_rsp.delete();
            pending = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                    report_mismatch("response transaction with none outstanding, status",
                                    rsp.status, 0);
                else
                begin
                    oldest = awaited_rsp.pop_front();
                    if (rsp.status != oldest.status)
                        report_mismatch("status", rsp.status, oldest.status);
                    if (rsp.slot != oldest.slot)
                        report_mismatch("slot", rsp.slot, oldest.slot);
                end
            end
            if (req_valid && req_ready)
                awaited_rsp.insert(awaited_rsp.size(), serve_request(req));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TABLE_SIZE: size_reg = cfg_data[TSIZE_W-1:0];
                    REG_PROBE_MODE: mode_reg = cfg_data[0];
                    default: ;
                endcase
            end
            pending = awaited_rsp.size();
        end
    end

endmodule

@@ bench/open_address_hash_table_unit_tb.sv @@
module open_address_hash_table_unit_tb;
    import oaht_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLDOFF_CYCLES  = 400;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    int                   fail_count;
    int                   pending;

    // Traffic shaping, changed per phase.
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int rsp_holdoff   = 0;
    int cycle_count   = 0;

    // Keys offered for insert so far; lookups mostly draw from here.
    logic [KEY_W-1:0] key_pool [$];

    // Table size and probe mode of each random phase, mostly growing so that
    // inserts keep finding free slots for a while.
    int phase_size [NUM_PHASES] = '{2, 3, 4, 5, 6, 8, 10, 12, 16, 0, 17, 16};
    int phase_mode [NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1};

    always #5 clk = ~clk;

    open_address_hash_table_unit dut (.*);

    hash_table_checker table_check (.*);

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Response side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rsp_holdoff > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_holdoff--;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Write one register; leaves the write enable low for a full cycle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering and wait until every response has come back.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Offer one request transaction, with an optional idle gap before it,
    // and return at the falling edge after it was taken.
    task automatic offer_request(input logic kind, input logic [KEY_W-1:0] k);
        req_t r;
        r.req_type = kind;
        r.key      = k;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        if (kind == REQ_INSERT)
            key_pool.insert(key_pool.size(), k);
    endtask

    // About half keys seen before, otherwise small values, extremes or anything.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50 && key_pool.size() > 0)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        if (sel < 70)
            return $urandom_range(63);
        if (sel < 75)
            return $urandom_range(1) ? '1 : '0;
        return $urandom();
    endfunction

    initial
    begin
        logic [CFG_W-1:0] mode_word;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, collisions, duplicates, extreme keys.
        offer_request(REQ_INSERT, 32'd0);
        offer_request(REQ_INSERT, 32'hFFFF_FFFF);
        offer_request(REQ_LOOKUP, 32'd0);
        offer_request(REQ_LOOKUP, 32'hFFFF_FFFF);
        offer_request(REQ_LOOKUP, 32'd22);
        offer_request(REQ_INSERT, 32'd11);
        offer_request(REQ_INSERT, 32'd0);
        offer_request(REQ_LOOKUP, 32'd11);

        // Quadratic probing over the same contents.
        wait_idle();
        write_reg(REG_PROBE_MODE, CFG_W'(MODE_QUADRATIC));
        offer_request(REQ_INSERT, 32'd22);
        offer_request(REQ_LOOKUP, 32'd22);

        // One slot: full table on insert, lookup running out of probes.
        wait_idle();
        write_reg(REG_TABLE_SIZE, 5'd1);
        offer_request(REQ_INSERT, 32'd7);
        offer_request(REQ_LOOKUP, 32'd7);
        offer_request(REQ_LOOKUP, 32'd0);

        // Size zero behaves as one.
        wait_idle();
        write_reg(REG_TABLE_SIZE, 5'd0);
        offer_request(REQ_LOOKUP, 32'd0);
        offer_request(REQ_INSERT, 32'd5);

        // Largest register value clamps to the full depth.
        wait_idle();
        write_reg(REG_TABLE_SIZE, 5'd31);
        write_reg(REG_PROBE_MODE, CFG_W'(MODE_LINEAR));
        offer_request(REQ_INSERT, 32'd16);
        offer_request(REQ_INSERT, 32'h8000_000F);
        offer_request(REQ_LOOKUP, 32'h8000_000F);

        // Two slots with quadratic probing: both reachable slots taken.
        wait_idle();
        write_reg(REG_TABLE_SIZE, 5'd2);
        write_reg(REG_PROBE_MODE, CFG_W'(MODE_QUADRATIC));
        offer_request(REQ_INSERT, 32'd3);
        offer_request(REQ_LOOKUP, 32'd3);

        wait_idle();
        write_reg(REG_TABLE_SIZE, 5'd16);
        offer_request(REQ_LOOKUP, 32'd12345);
        offer_request(REQ_INSERT, 32'h5555_5555);
        offer_request(REQ_LOOKUP, 32'hAAAA_AAAA);

        // Random phases, each with its own size, mode and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_reg(REG_TABLE_SIZE, CFG_W'(phase_size[p]));
            // Upper data bits of the mode write carry noise.
            mode_word = CFG_W'(($urandom_range(15) << 1) | phase_mode[p]);
            write_reg(REG_PROBE_MODE, mode_word);
            case (p % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 83;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 83;
                end
                default:
                begin
                    tx_idle_pct  = 17;
                    rx_stall_pct = 17;
                end
            endcase
            // Long receiver hold-off while requests keep coming.
            if (p == 0)
                rsp_holdoff = HOLDOFF_CYCLES;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Sender pause until the block has answered everything.
                if (p == 5 && i == ITEMS_PER_PHASE / 2)
                    wait_idle();
                offer_request(($urandom_range(99) < 40) ? REQ_INSERT : REQ_LOOKUP, pick_key());
            end
        end

        // Drain and let any stray response show up.
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
